[src/cemc_pkg.sv]
package cemc_pkg;

   localparam int CORDIC_STEPS = 28;
   localparam int CW           = 42;   // CORDIC x/y datapath width, signed
   localparam int AW           = 35;   // angle width, 2^-32 turn units, signed
   localparam int TW           = 33;   // clamped turn fraction, 0 .. 2^32
   localparam int FRAC_BITS    = 16;
   localparam int POS_W        = 31;   // source position in Q(FRAC_BITS)
   localparam int COORD_W      = 13;
   localparam int WEIGHT_W     = 17;
   localparam int PRESCALE_SH  = 24;

   localparam logic signed [25:0] GAIN_Q24 = 26'sd27628053;
   localparam logic signed [AW-1:0] HALF_TURN = AW'(64'sd2147483648);
   localparam logic [TW-1:0] FULL_TURN = {1'b1, {(TW-1){1'b0}}};
   localparam logic [COORD_W-1:0] COORD_LIMIT = {COORD_W{1'b1}};

   localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
      32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
      32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
      32'd166886,    32'd83443,     32'd41722,     32'd20861,
      32'd10430,     32'd5215,      32'd2608,      32'd1304,
      32'd652,       32'd326,       32'd163,       32'd81,
      32'd41,        32'd20,        32'd10,        32'd5
   };

   localparam logic CSR_FACE_SIZE = 1'b0;
   localparam logic CSR_EQ_HEIGHT = 1'b1;

   typedef struct packed {
      logic [2:0]  face;
      logic [10:0] col;
      logic [10:0] row;
   } req_type;

   typedef struct packed {
      logic [COORD_W-1:0]  u_left;
      logic [COORD_W-1:0]  u_right;
      logic [COORD_W-1:0]  v_top;
      logic [COORD_W-1:0]  v_bottom;
      logic [WEIGHT_W-1:0] weight_x;
      logic [WEIGHT_W-1:0] weight_y;
   } rsp_type;

   typedef struct packed {
      logic valid;
      logic zero;
   } cordic_ctl_type;

endpackage

[src/cemc_cordic.sv]
module cemc_cordic (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           en,
   input  cemc_pkg::cordic_ctl_type       in_ctl,
   input  logic signed [cemc_pkg::CW-1:0] in_x,
   input  logic signed [cemc_pkg::CW-1:0] in_y,
   input  logic signed [cemc_pkg::AW-1:0] in_ang,
   output logic                           out_valid,
   output logic signed [cemc_pkg::CW-1:0] out_x,
   output logic signed [cemc_pkg::AW-1:0] out_ang
);
   import cemc_pkg::*;

   cordic_ctl_type        ctl_ff [CORDIC_STEPS];
   logic signed [CW-1:0]  x_ff   [CORDIC_STEPS];
   logic signed [CW-1:0]  y_ff   [CORDIC_STEPS];
   logic signed [AW-1:0]  ang_ff [CORDIC_STEPS];

   // one micro-rotation per stage
   for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
      cordic_ctl_type       ctl_in;
      logic signed [CW-1:0] x_src, y_src, x_in, y_in;
      logic signed [AW-1:0] ang_src, ang_in;

      if (k == 0) begin : g_first
         assign ctl_in  = in_ctl;
         assign x_src   = in_x;
         assign y_src   = in_y;
         assign ang_src = in_ang;
      end else begin : g_next
         assign ctl_in  = ctl_ff[k-1];
         assign x_src   = x_ff[k-1];
         assign y_src   = y_ff[k-1];
         assign ang_src = ang_ff[k-1];
      end

      always_comb begin
         if (y_src > 0) begin
            x_in   = x_src + (y_src >>> k);
            y_in   = y_src - (x_src >>> k);
            ang_in = ang_src + AW'(ATAN_TURNS[k]);
         end else begin
            x_in   = x_src - (y_src >>> k);
            y_in   = y_src + (x_src >>> k);
            ang_in = ang_src - AW'(ATAN_TURNS[k]);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[k] <= '0;
         end else if (en) begin
            ctl_ff[k] <= ctl_in;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[k]   <= x_in;
            y_ff[k]   <= y_in;
            ang_ff[k] <= ang_in;
         end
      end
   end

   assign out_valid = ctl_ff[CORDIC_STEPS-1].valid;
   assign out_x     = x_ff[CORDIC_STEPS-1];
   // zero vector: atan2(0,0) reads as zero
   assign out_ang   = ctl_ff[CORDIC_STEPS-1].zero ? '0 : ang_ff[CORDIC_STEPS-1];

endmodule

[src/cemc_coord.sv]
module cemc_coord (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           en,
   input  logic                           in_valid,
   input  logic [cemc_pkg::TW-1:0]        in_theta_turn,
   input  logic signed [cemc_pkg::AW-1:0] in_phi,
   input  logic [11:0]                    face_size,
   input  logic [13:0]                    eq_height,
   output logic                           out_valid,
   output cemc_pkg::rsp_type              out_data
);
   import cemc_pkg::*;

   logic [2:0]            valid_ff;
   logic [TW-1:0]         tu_ff, tv_ff;
   logic [POS_W-1:0]      uf_ff, vf_ff;
   rsp_type               rsp_ff, rsp_in;

   logic signed [AW:0]    tv_raw;
   logic [TW-1:0]         tv_in;
   logic [13:0]           map_w;
   logic [TW+13:0]        uprod, vprod;
   logic [COORD_W-1:0]    wmax, hmax;
   logic [13:0]           wmax_raw, hmax_raw;
   logic [14:0]           uidx, vidx;
   logic                  u_over, v_over;

   // latitude term: 1/2 - 2*phi, clamped to [0, 1] turn
   always_comb begin
      tv_raw = {HALF_TURN[AW-1], HALF_TURN} - (AW+1)'({in_phi, 1'b0});
      if (tv_raw < 0) begin
         tv_in = '0;
      end else if (tv_raw > $signed({3'b000, FULL_TURN})) begin
         tv_in = FULL_TURN;
      end else begin
         tv_in = tv_raw[TW-1:0];
      end
   end

   assign map_w = {face_size, 2'b00};
   assign uprod = map_w * tu_ff;
   assign vprod = eq_height * tv_ff;

   always_comb begin
      wmax_raw = (face_size != '0) ? map_w - 14'd1 : '0;
      hmax_raw = (eq_height != '0) ? eq_height - 14'd1 : '0;
      wmax     = wmax_raw[13] ? COORD_LIMIT : wmax_raw[COORD_W-1:0];
      hmax     = hmax_raw[13] ? COORD_LIMIT : hmax_raw[COORD_W-1:0];

      uidx   = uf_ff[POS_W-1:FRAC_BITS];
      vidx   = vf_ff[POS_W-1:FRAC_BITS];
      u_over = uidx > {2'b00, wmax};
      v_over = vidx > {2'b00, hmax};

      rsp_in.u_left   = u_over ? wmax : uidx[COORD_W-1:0];
      rsp_in.u_right  = (rsp_in.u_left == wmax) ? wmax : rsp_in.u_left + 1'b1;
      rsp_in.v_top    = v_over ? hmax : vidx[COORD_W-1:0];
      rsp_in.v_bottom = (rsp_in.v_top == hmax) ? hmax : rsp_in.v_top + 1'b1;
      // clamped corner sits below the sample: weight saturates at one
      rsp_in.weight_x = u_over ? {1'b1, {FRAC_BITS{1'b0}}}
                               : {1'b0, uf_ff[FRAC_BITS-1:0]};
      rsp_in.weight_y = v_over ? {1'b1, {FRAC_BITS{1'b0}}}
                               : {1'b0, vf_ff[FRAC_BITS-1:0]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tu_ff  <= in_theta_turn;
         tv_ff  <= tv_in;
         uf_ff  <= uprod[TW+13:32-FRAC_BITS];
         vf_ff  <= vprod[TW+13:32-FRAC_BITS];
         rsp_ff <= rsp_in;
      end
   end

   assign out_valid = valid_ff[2];
   assign out_data  = rsp_ff;

endmodule

[src/cubemap_to_equirect_sample_coords.sv]
// Depth: 61 register stages: 1 face map stage, 2 x 28 CORDIC rotation stages,
//   3 coordinate stages and an output register with a one-entry skid.
// Throughput: one beat per cycle while req_stall is low.
// req_stall rises only when the skid entry is occupied; the whole pipe then holds.
// Reset (synchronous, active high) empties the pipe and loads face_size 512,
//   eq_height 1024.
module cubemap_to_equirect_sample_coords (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  cemc_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output cemc_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [13:0]       csr_wdata
);
   import cemc_pkg::*;

   // ---------------- configuration ----------------
   logic [11:0] face_size_ff;
   logic [13:0] eq_height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         face_size_ff <= 12'd512;
         eq_height_ff <= 14'd1024;
      end else if (csr_we) begin
         case (csr_index)
            CSR_FACE_SIZE: face_size_ff <= csr_wdata[11:0];
            CSR_EQ_HEIGHT: eq_height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------- flow control ----------------
   // The pipe advances as one; it freezes only while the skid entry holds a beat.
   logic    en;
   logic    rsp_valid_ff, skid_valid_ff;
   rsp_type rsp_ff, skid_ff;
   logic    pipe_valid;
   rsp_type pipe_data;
   logic    take;

   assign en        = !skid_valid_ff;
   assign req_stall = skid_valid_ff;
   assign take      = rsp_valid_ff && !rsp_stall;

   // ---------------- stage 0: face to direction ----------------
   // a, b: texel centre times face_size; face axis is +-face_size.
   logic signed [13:0] fs_s, a14, b14;
   logic signed [12:0] a, b, f, x, y, z, x_rot, y_rot;
   logic signed [AW-1:0] ang0_in;
   logic               zero_xy, zero_xyz;

   logic                 s0_valid_ff, s0_zero_xy_ff, s0_zero_xyz_ff;
   logic signed [12:0]   s0_x_ff, s0_y_ff, s0_z_ff;
   logic signed [AW-1:0] s0_ang_ff;

   always_comb begin
      fs_s = $signed({2'b00, face_size_ff});
      a14  = $signed({2'b00, req_data.col, 1'b1}) - fs_s;
      b14  = $signed({2'b00, req_data.row, 1'b1}) - fs_s;
      a    = a14[12:0];
      b    = b14[12:0];
      f    = fs_s[12:0];
      case (req_data.face)
         3'd0: begin x = f;  y = -b; z = -a; end
         3'd1: begin x = -f; y = -b; z = a;  end
         3'd2: begin x = a;  y = f;  z = b;  end
         3'd3: begin x = a;  y = -f; z = -b; end
         3'd4: begin x = a;  y = -b; z = f;  end
         3'd5: begin x = -a; y = -b; z = -f; end
         default: begin x = '0; y = '0; z = '0; end
      endcase
      zero_xy  = (x == '0) && (y == '0);
      zero_xyz = zero_xy && (z == '0);
      // left half plane: rotate by a half turn before the micro-rotations
      if (x < 0) begin
         x_rot   = -x;
         y_rot   = -y;
         ang0_in = (y >= 0) ? HALF_TURN : -HALF_TURN;
      end else begin
         x_rot   = x;
         y_rot   = y;
         ang0_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (en) begin
         s0_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s0_x_ff        <= x_rot;
         s0_y_ff        <= y_rot;
         s0_z_ff        <= z;
         s0_ang_ff      <= ang0_in;
         s0_zero_xy_ff  <= zero_xy;
         s0_zero_xyz_ff <= zero_xyz;
      end
   end

   // ---------------- longitude CORDIC ----------------
   logic signed [CW-1:0] c1_x_in, c1_y_in, c1_x_out;
   logic signed [AW-1:0] c1_ang_out;
   logic                 c1_valid;
   cordic_ctl_type       c1_ctl;

   // operands scaled by 2^24
   assign c1_x_in = {{(CW-13-PRESCALE_SH){s0_x_ff[12]}}, s0_x_ff, {PRESCALE_SH{1'b0}}};
   assign c1_y_in = {{(CW-13-PRESCALE_SH){s0_y_ff[12]}}, s0_y_ff, {PRESCALE_SH{1'b0}}};
   assign c1_ctl  = '{valid: s0_valid_ff, zero: s0_zero_xy_ff};

   cemc_cordic u_cordic_lon (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_ctl    (c1_ctl),
      .in_x      (c1_x_in),
      .in_y      (c1_y_in),
      .in_ang    (s0_ang_ff),
      .out_valid (c1_valid),
      .out_x     (c1_x_out),
      .out_ang   (c1_ang_out)
   );

   // z times the CORDIC gain rides alongside, to meet the gained magnitude
   logic signed [38:0] zg_in;
   logic signed [38:0] zg_ff   [CORDIC_STEPS];
   logic               zz_ff   [CORDIC_STEPS];

   assign zg_in = s0_z_ff * GAIN_Q24;

   always_ff @(posedge clock) begin
      if (en) begin
         zg_ff[0] <= zg_in;
         zz_ff[0] <= s0_zero_xyz_ff;
         for (int i = 1; i < CORDIC_STEPS; i++) begin
            zg_ff[i] <= zg_ff[i-1];
            zz_ff[i] <= zz_ff[i-1];
         end
      end
   end

   // ---------------- latitude CORDIC ----------------
   logic signed [CW-1:0] c2_y_in, c2_x_unused;
   logic signed [AW-1:0] c2_ang_out;
   logic                 c2_valid;
   cordic_ctl_type       c2_ctl;
   logic signed [AW:0]   tu_raw;
   logic [TW-1:0]        tu_in;

   assign c2_y_in = {{(CW-39){zg_ff[CORDIC_STEPS-1][38]}}, zg_ff[CORDIC_STEPS-1]};
   assign c2_ctl  = '{valid: c1_valid, zero: zz_ff[CORDIC_STEPS-1]};

   cemc_cordic u_cordic_lat (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_ctl    (c2_ctl),
      .in_x      (c1_x_out),
      .in_y      (c2_y_in),
      .in_ang    ('0),
      .out_valid (c2_valid),
      .out_x     (c2_x_unused),
      .out_ang   (c2_ang_out)
   );

   // longitude term: theta + 1/2, clamped to [0, 1] turn, delayed to meet phi
   always_comb begin
      tu_raw = {c1_ang_out[AW-1], c1_ang_out} + {HALF_TURN[AW-1], HALF_TURN};
      if (tu_raw < 0) begin
         tu_in = '0;
      end else if (tu_raw > $signed({3'b000, FULL_TURN})) begin
         tu_in = FULL_TURN;
      end else begin
         tu_in = tu_raw[TW-1:0];
      end
   end

   logic [TW-1:0] tu_ff [CORDIC_STEPS];

   always_ff @(posedge clock) begin
      if (en) begin
         tu_ff[0] <= tu_in;
         for (int i = 1; i < CORDIC_STEPS; i++) begin
            tu_ff[i] <= tu_ff[i-1];
         end
      end
   end

   // ---------------- scaling and bilinear corners ----------------
   cemc_coord u_coord (
      .clock         (clock),
      .reset         (reset),
      .en            (en),
      .in_valid      (c2_valid),
      .in_theta_turn (tu_ff[CORDIC_STEPS-1]),
      .in_phi        (c2_ang_out),
      .face_size     (face_size_ff),
      .eq_height     (eq_height_ff),
      .out_valid     (pipe_valid),
      .out_data      (pipe_data)
   );

   // ---------------- output register and skid ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (en && pipe_valid) begin
            if (!rsp_valid_ff || take) begin
               rsp_valid_ff <= 1'b1;
            end else begin
               skid_valid_ff <= 1'b1;
            end
         end else if (skid_valid_ff && (!rsp_valid_ff || take)) begin
            rsp_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else if (take) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en && pipe_valid) begin
         if (!rsp_valid_ff || take) begin
            rsp_ff <= pipe_data;
         end else begin
            skid_ff <= pipe_data;
         end
      end else if (skid_valid_ff && (!rsp_valid_ff || take)) begin
         rsp_ff <= skid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // ---------------- checks ----------------
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid entry held with empty output register");

   a_weight_x_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_ff.weight_x <= {1'b1, {FRAC_BITS{1'b0}}})
      else $error("weight_x above one");

   a_u_pair: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.u_right == rsp_ff.u_left) ||
                       (rsp_ff.u_right == rsp_ff.u_left + 1'b1))
      else $error("u corners not adjacent");

   a_v_pair: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.v_bottom == rsp_ff.v_top) ||
                       (rsp_ff.v_bottom == rsp_ff.v_top + 1'b1))
      else $error("v corners not adjacent");

endmodule
